FILE: hw/rtl/hdc_pkg.sv
// shared types and constants for the hash dictionary word compressor
// no dependencies; imported by every module of the block
`default_nettype none

package hdc_pkg;

  localparam int WORD_W  = 32;
  localparam int EPOCH_W = 8;
  localparam int MEM_W   = EPOCH_W + WORD_W;

  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  localparam logic [WORD_W-1:0] BASIS_RESET = 32'd2166136261;
  localparam logic [WORD_W-1:0] PRIME_RESET = 32'd16777619;

  // configuration register indexes
  localparam logic [0:0] REG_OFFSET_BASIS = 1'b0;
  localparam logic [0:0] REG_PRIME        = 1'b1;

  typedef enum logic [0:0] {
    KIND_COMPRESS = 1'b0,
    KIND_CLEAR    = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_SETTLE,
    ST_RUN
  } dict_state_e;

  typedef struct packed {
    kind_e             kind;
    logic [WORD_W-1:0] word;
  } item_t;

  typedef struct packed {
    logic              is_match;
    logic [WORD_W-1:0] literal_word;
  } result_t;

  // pipeline control between the dictionary and the top level
  typedef struct packed {
    logic run;
    logic advance;
  } pipe_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hdc_hash.sv
// hash front end: xor with basis, multiply by prime, fold to the index width
// depends on hdc_pkg
`default_nettype none

module hdc_hash
  import hdc_pkg::*;
#(
  parameter int HASH_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  advance,
  input  wire logic                  in_valid,
  input  wire item_t                 in_item,
  input  wire logic [WORD_W-1:0]     basis,
  input  wire logic [WORD_W-1:0]     prime,
  output logic                       s2_valid,
  output item_t                      s2_item,
  output logic [HASH_WIDTH-1:0]      s2_idx
);

  logic              s1_valid;
  item_t             s1_item;
  logic [WORD_W-1:0] s1_x;
  logic [WORD_W-1:0] s2_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item <= in_item;
      s1_x    <= basis ^ in_item.word;
      s2_item <= s1_item;
      // product modulo two to the 32
      s2_h    <= s1_x * prime;
    end
  end

  assign s2_idx = s2_h[WORD_W-1 -: HASH_WIDTH] ^ s2_h[HASH_WIDTH-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/hdc_dict.sv
// dictionary memory with epoch tags, lookup and replace, clearing sweep
// depends on hdc_pkg
`default_nettype none

module hdc_dict
  import hdc_pkg::*;
#(
  parameter int HASH_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  advance,
  input  wire logic                  s2_valid,
  input  wire item_t                 s2_item,
  input  wire logic [HASH_WIDTH-1:0] s2_idx,
  output logic                       run,
  output logic                       res_valid,
  output result_t                    res,
  output logic [HASH_WIDTH-1:0]      res_idx
);

  localparam int DEPTH = 1 << HASH_WIDTH;

  logic [MEM_W-1:0] mem [DEPTH];

  dict_state_e state, state_next;
  logic [HASH_WIDTH-1:0] sweep_cnt;
  logic [EPOCH_W-1:0]    epoch;

  logic                  s3_valid;
  item_t                 s3_item;
  logic [HASH_WIDTH-1:0] s3_idx;

  logic [HASH_WIDTH-1:0] rd_addr;
  logic [MEM_W-1:0]      rd_data;

  logic                  wr_en;
  logic [HASH_WIDTH-1:0] wr_addr;
  logic [MEM_W-1:0]      wr_data;

  logic                  fwd_valid;
  logic [HASH_WIDTH-1:0] fwd_addr;
  logic [WORD_W-1:0]     fwd_word;

  logic [EPOCH_W-1:0]    ent_epoch;
  logic [WORD_W-1:0]     ent_word;
  logic                  hit;
  logic                  do_compress;
  logic                  do_clear;
  logic                  replace;
  logic                  start_sweep;

  assign run = (state == ST_RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_SWEEP: begin
        if (sweep_cnt == '1) state_next = ST_SETTLE;
      end
      ST_SETTLE: begin
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (start_sweep) state_next = ST_SWEEP;
      end
      default: begin
        state_next = ST_SWEEP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_item <= s2_item;
      s3_idx  <= s2_idx;
    end
  end

  // when held, reread the entry of the waiting item so its data stays current
  assign rd_addr = advance ? s2_idx : s3_idx;

  // the write made last cycle is not yet in rd_data
  assign ent_epoch = (fwd_valid && fwd_addr == s3_idx) ? epoch : rd_data[MEM_W-1 -: EPOCH_W];
  assign ent_word  = (fwd_valid && fwd_addr == s3_idx) ? fwd_word : rd_data[WORD_W-1:0];
  assign hit       = (ent_epoch == epoch) && (ent_word == s3_item.word);

  assign do_compress = advance && s3_valid && (s3_item.kind == KIND_COMPRESS);
  assign do_clear    = advance && s3_valid && (s3_item.kind == KIND_CLEAR);
  assign replace     = do_compress && !hit;
  assign start_sweep = do_clear && (epoch == EPOCH_LAST);

  always_comb begin
    if (state == ST_SWEEP) begin
      wr_en   = 1'b1;
      wr_addr = sweep_cnt;
      wr_data = '0;
    end else begin
      wr_en   = replace;
      wr_addr = s3_idx;
      wr_data = {epoch, s3_item.word};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
      sweep_cnt <= '0;
      epoch     <= EPOCH_FIRST;
    end else begin
      fwd_valid <= replace;
      if (state == ST_SWEEP) sweep_cnt <= sweep_cnt + 1'b1;
      // epoch zero marks swept entries; a new era starts at one
      if (start_sweep) begin
        epoch <= EPOCH_FIRST;
      end else if (do_clear) begin
        epoch <= epoch + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (replace) begin
      fwd_addr <= s3_idx;
      fwd_word <= s3_item.word;
    end
  end

  assign res_valid        = do_compress;
  assign res.is_match     = hit;
  assign res.literal_word = hit ? '0 : s3_item.word;
  assign res_idx          = hit ? s3_idx : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/hdc_out.sv
// output register with a skid stage for the result stream
// depends on hdc_pkg
`default_nettype none

module hdc_out
  import hdc_pkg::*;
#(
  parameter int HASH_WIDTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire result_t                      push_res,
  input  wire logic [HASH_WIDTH-1:0]        push_idx,
  output logic                              skid_full,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [WORD_W+HASH_WIDTH-1:0]      m_tdata,
  output logic                              m_tuser
);

  result_t               out_res, skid_res;
  logic [HASH_WIDTH-1:0] out_idx, skid_idx;
  logic                  take;

  assign take = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (take) begin
        m_tvalid  <= 1'b1;
        skid_full <= 1'b0;
      end
    end else if (take) begin
      m_tvalid <= push;
    end else if (push) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (take) begin
        out_res <= skid_res;
        out_idx <= skid_idx;
      end
    end else if (push) begin
      if (take) begin
        out_res <= push_res;
        out_idx <= push_idx;
      end else begin
        skid_res <= push_res;
        skid_idx <= push_idx;
      end
    end
  end

  assign m_tdata = {out_idx, out_res.literal_word};
  assign m_tuser = out_res.is_match;

endmodule

`default_nettype wire

FILE: hw/rtl/hash_dictionary_word_compressor_unit.sv
// Hash dictionary word compressor, top level: one word or clear request per cycle
// while s_tready is high. Sustained rate is one request per clock outside sweeps and
// skid stalls; the dictionary RAM does one read and at most one write each cycle. A
// request passes through the s1, s2 and s3 registers before its result reaches the
// output register. Clear requests produce no result and cost nothing extra, except
// every 255th clear since the last sweep, and reset itself, start a sweep of the
// 2^HASH_WIDTH entries followed by a settle state, during which s_tready is low;
// configuration writes are taken at any time. Results travel through an output
// register and a skid stage, so a waiting result does not stall the input by itself.
// depends on hdc_pkg, hdc_hash, hdc_dict, hdc_out
`default_nettype none

module hash_dictionary_word_compressor_unit
  import hdc_pkg::*;
#(
  parameter int HASH_WIDTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // config write port
  input  wire logic                        cfg_we,
  input  wire logic [0:0]                  cfg_index,
  input  wire logic [WORD_W-1:0]           cfg_data,
  // request stream
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [WORD_W-1:0]           s_tdata,   // [31:0] word_value
  input  wire logic                        s_tuser,   // [0] kind
  // result stream
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [WORD_W+HASH_WIDTH-1:0]     m_tdata,   // [31:0] literal_word, then dict_index
  output logic                             m_tuser    // [0] is_match
);

  logic [WORD_W-1:0] basis;
  logic [WORD_W-1:0] prime;

  pipe_ctl_t ctl;
  logic      skid_full;

  item_t                 in_item;
  logic                  s2_valid;
  item_t                 s2_item;
  logic [HASH_WIDTH-1:0] s2_idx;

  logic                  res_valid;
  result_t               res;
  logic [HASH_WIDTH-1:0] res_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      basis <= BASIS_RESET;
      prime <= PRIME_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET_BASIS: basis <= cfg_data;
        REG_PRIME:        prime <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign ctl.advance = ctl.run && !skid_full;
  assign s_tready    = ctl.advance;

  assign in_item.kind = kind_e'(s_tuser);
  assign in_item.word = s_tdata;

  hdc_hash #(
    .HASH_WIDTH(HASH_WIDTH)
  ) u_hash (
    .clk      (clk),
    .rst      (rst),
    .advance  (ctl.advance),
    .in_valid (s_tvalid),
    .in_item  (in_item),
    .basis    (basis),
    .prime    (prime),
    .s2_valid (s2_valid),
    .s2_item  (s2_item),
    .s2_idx   (s2_idx)
  );

  hdc_dict #(
    .HASH_WIDTH(HASH_WIDTH)
  ) u_dict (
    .clk       (clk),
    .rst       (rst),
    .advance   (ctl.advance),
    .s2_valid  (s2_valid),
    .s2_item   (s2_item),
    .s2_idx    (s2_idx),
    .run       (ctl.run),
    .res_valid (res_valid),
    .res       (res),
    .res_idx   (res_idx)
  );

  hdc_out #(
    .HASH_WIDTH(HASH_WIDTH)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_res  (res),
    .push_idx  (res_idx),
    .skid_full (skid_full),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire

FILE: sim/hash_dictionary_word_compressor_unit_test.sv
// self-checking bench for the hash dictionary word compressor top level
// drives the request stream and the config port, predicts every code, checks the result stream
// depends on hdc_pkg and the rtl under hw/rtl
module hash_dictionary_word_compressor_unit_test;
  import hdc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HW     = 16;
  localparam int SLOTS  = 1 << HW;
  localparam int SETTLE = 16;
  localparam int HOLD   = 400;

  typedef struct packed {
    logic              is_match;
    logic [WORD_W-1:0] literal_word;
    logic [HW-1:0]     dict_index;
  } code_t;

  typedef struct {
    kind_e             kind;
    logic [WORD_W-1:0] word;
    bit                typed;
    code_t             code;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [0:0]        cfg_index = REG_OFFSET_BASIS;
  logic [WORD_W-1:0] cfg_data = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [WORD_W-1:0] s_tdata = '0;
  logic              s_tuser = KIND_COMPRESS;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [WORD_W+HW-1:0] m_tdata;
  logic              m_tuser;

  hash_dictionary_word_compressor_unit #(
    .HASH_WIDTH(HW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: a slot is valid when its generation equals the current one
  logic [WORD_W-1:0] hash_basis = BASIS_RESET;
  logic [WORD_W-1:0] hash_mult = PRIME_RESET;
  int unsigned       slot_generation [0:SLOTS-1];
  logic [WORD_W-1:0] slot_word [0:SLOTS-1];
  int unsigned       dict_generation = 1;

  code_t       pending_codes[$];
  logic [WORD_W-1:0] word_pool [0:7] = '{32'h0, 32'hFFFFFFFF, 32'h1, 32'h80000000,
                                          32'hDEADBEEF, 32'h12345678, 32'hA5A5A5A5,
                                          32'h5A5A5A5A};
  bit          sender_gaps = 1'b1;
  bit          receiver_stalls = 1'b1;
  bit          hold_pending = 1'b0;
  int unsigned mismatches = 0;
  int unsigned n_requests = 0;
  int unsigned n_clears = 0;
  int unsigned n_matches = 0;
  int unsigned n_literals = 0;
  int unsigned n_settings = 0;

  stim_row_t directed_rows [0:19] = '{
    '{KIND_COMPRESS, 32'h00000000, 1'b1, '{1'b0, 32'h00000000, 16'h0}},
    '{KIND_COMPRESS, 32'h00000000, 1'b0, '0},
    '{KIND_COMPRESS, 32'hFFFFFFFF, 1'b1, '{1'b0, 32'hFFFFFFFF, 16'h0}},
    '{KIND_COMPRESS, 32'hFFFFFFFF, 1'b0, '0},
    '{KIND_COMPRESS, 32'h00000000, 1'b0, '0},
    '{KIND_CLEAR,    32'hDEADBEEF, 1'b0, '0},
    '{KIND_COMPRESS, 32'h00000000, 1'b1, '{1'b0, 32'h00000000, 16'h0}},
    '{KIND_COMPRESS, 32'hFFFFFFFF, 1'b1, '{1'b0, 32'hFFFFFFFF, 16'h0}},
    '{KIND_COMPRESS, 32'h80000000, 1'b1, '{1'b0, 32'h80000000, 16'h0}},
    '{KIND_COMPRESS, 32'h00000001, 1'b1, '{1'b0, 32'h00000001, 16'h0}},
    '{KIND_COMPRESS, 32'h12345678, 1'b0, '0},
    '{KIND_COMPRESS, 32'h12345678, 1'b0, '0},
    '{KIND_COMPRESS, 32'hA5A5A5A5, 1'b0, '0},
    '{KIND_COMPRESS, 32'h5A5A5A5A, 1'b0, '0},
    '{KIND_COMPRESS, 32'h80000000, 1'b0, '0},
    '{KIND_COMPRESS, 32'h00000001, 1'b0, '0},
    '{KIND_CLEAR,    32'h00000000, 1'b0, '0},
    '{KIND_CLEAR,    32'hFFFFFFFF, 1'b0, '0},
    '{KIND_COMPRESS, 32'h12345678, 1'b1, '{1'b0, 32'h12345678, 16'h0}},
    '{KIND_COMPRESS, 32'h12345678, 1'b0, '0}
  };

  function automatic logic [HW-1:0] fold_index(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] prod;
    prod = (hash_basis ^ w) * hash_mult;
    return prod[31:16] ^ prod[15:0];
  endfunction

  function automatic void compress_predict(input kind_e k, input logic [WORD_W-1:0] w,
                                           output bit produces, output code_t c);
    logic [HW-1:0] idx;
    c = '0;
    produces = 1'b0;
    if (k == KIND_CLEAR) begin
      dict_generation++;
      return;
    end
    idx = fold_index(w);
    produces = 1'b1;
    if (slot_generation[idx] == dict_generation && slot_word[idx] == w) begin
      c.is_match = 1'b1;
      c.dict_index = idx;
    end else begin
      slot_generation[idx] = dict_generation;
      slot_word[idx] = w;
      c.literal_word = w;
    end
  endfunction

  // mostly recent words so matches happen; xor of both halves by the same value
  // keeps the fold unchanged under a unit prime, giving collisions there
  function automatic logic [WORD_W-1:0] pick_word();
    logic [WORD_W-1:0] w;
    logic [15:0]       d;
    int unsigned       r;
    r = $urandom_range(0, 99);
    d = 16'($urandom_range(1, 16'hFFFF));
    if (r < 45) begin
      w = word_pool[$urandom_range(0, 7)];
    end else if (r < 60) begin
      w = word_pool[$urandom_range(0, 7)] ^ {d, d};
    end else if (r < 72) begin
      case ($urandom_range(0, 4))
        0: w = '0;
        1: w = '1;
        2: w = 32'h1 << $urandom_range(0, 31);
        3: w = ~(32'h1 << $urandom_range(0, 31));
        default: w = {d, d};
      endcase
    end else begin
      w = $urandom;
    end
    word_pool[$urandom_range(0, 7)] = w;
    return w;
  endfunction

  task automatic load_hash(input logic [WORD_W-1:0] basis, input logic [WORD_W-1:0] prime);
    cfg_we <= 1'b1;
    cfg_index <= REG_OFFSET_BASIS;
    cfg_data <= basis;
    @(posedge clk);
    hash_basis = basis;
    cfg_index <= REG_PRIME;
    cfg_data <= prime;
    @(posedge clk);
    hash_mult = prime;
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // offer one request and hold it until the block takes it
  task automatic offer(input kind_e k, input logic [WORD_W-1:0] w, input bit typed,
                       input code_t typed_code);
    code_t c;
    bit    produces;
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= k;
    s_tdata <= w;
    do @(posedge clk); while (!s_tready);
    compress_predict(k, w, produces, c);
    if (produces) pending_codes.push_back(typed ? typed_code : c);
    n_requests++;
    if (k == KIND_CLEAR) n_clears++;
  endtask

  task automatic run_phase(input int n, input int clear_pct, input bit gaps, input bit stalls);
    kind_e k;
    sender_gaps = gaps;
    receiver_stalls = stalls;
    repeat (n) begin
      k = ($urandom_range(0, 99) < clear_pct) ? KIND_CLEAR : KIND_COMPRESS;
      offer(k, pick_word(), 1'b0, '0);
    end
  endtask

  // wait for every expected code, then let the pipeline empty before touching config
  task automatic settle();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (pending_codes.size() != 0 && waited < 300000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        m_tready <= 1'b0;
        repeat (HOLD) @(posedge clk);
        hold_pending = 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    code_t want;
    code_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.is_match = m_tuser;
      got.literal_word = m_tdata[WORD_W-1:0];
      got.dict_index = m_tdata[WORD_W+HW-1:WORD_W];
      if (got.is_match) n_matches++;
      else n_literals++;
      if (pending_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected code: match=%0b literal=%h index=%h",
                   got.is_match, got.literal_word, got.dict_index);
      end else begin
        want = pending_codes.pop_front();
        if (got.is_match !== want.is_match || got.literal_word !== want.literal_word ||
            got.dict_index !== want.dict_index) begin
          mismatches++;
          if (mismatches <= 10)
            $display("code mismatch: want match=%0b literal=%h index=%h, got %0b %h %h",
                     want.is_match, want.literal_word, want.dict_index,
                     got.is_match, got.literal_word, got.dict_index);
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    load_hash(BASIS_RESET, PRIME_RESET);
    foreach (directed_rows[i])
      offer(directed_rows[i].kind, directed_rows[i].word, directed_rows[i].typed,
            directed_rows[i].code);
    settle();
    // zero prime sends every word to slot zero
    load_hash('0, '0);
    run_phase(120, 3, 1'b1, 1'b1);
    settle();
    // long receiver hold with the sender pushing back to back
    load_hash('1, '1);
    hold_pending = 1'b1;
    run_phase(200, 3, 1'b0, 1'b1);
    settle();
    load_hash('0, 32'h1);
    run_phase(200, 3, 1'b1, 1'b1);
    settle();
    // clear heavy, enough clears to force a dictionary sweep
    load_hash(BASIS_RESET, PRIME_RESET);
    run_phase(450, 60, 1'b1, 1'b1);
    settle();
    load_hash($urandom, $urandom | 32'h1);
    run_phase(200, 3, 1'b1, 1'b0);
    settle();
    load_hash($urandom, $urandom);
    run_phase(150, 2, 1'b0, 1'b0);
    settle();
    if (pending_codes.size() != 0) begin
      $display("%0d expected codes never arrived", pending_codes.size());
      mismatches += pending_codes.size();
    end
    $display("%0d requests (%0d clears) under %0d hash settings", n_requests, n_clears,
             n_settings);
    $display("%0d codes seen: %0d matches, %0d literals, %0d mismatches", n_matches + n_literals,
             n_matches, n_literals, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/hdc_pkg.sv
hw/rtl/hdc_hash.sv
hw/rtl/hdc_dict.sv
hw/rtl/hdc_out.sv
hw/rtl/hash_dictionary_word_compressor_unit.sv
sim/hash_dictionary_word_compressor_unit_test.sv
